### src/pcfs_pkg.sv
// shared types and constants for the pack precharge fault sequencer
package pcfs_pkg;

    localparam int TIMER_BITS_DEF = 12;
    localparam int TICK_W         = 12;
    localparam int CELL_W         = 16;
    localparam int FLAG_W         = 13;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [TICK_W-1:0] PRE_TICKS_RST = TICK_W'(2500);
    localparam logic [TICK_W-1:0] OVL_TICKS_RST = TICK_W'(500);
    localparam logic [CELL_W-1:0] LOW_CELL_RST  = CELL_W'(27500);
    localparam logic [CELL_W-1:0] HIGH_CELL_RST = CELL_W'(42000);

    // cell message count from which readings count against the limits
    localparam logic [1:0] CNT_SAT = 2'd3;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_PERMIT = 2'd1,
        ACT_ERRORS = 2'd2,
        ACT_CELL   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_TICKS = 2'd0,
        CFG_OVL_TICKS = 2'd1,
        CFG_LOW_CELL  = 2'd2,
        CFG_HIGH_CELL = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_ARMED = 2'd0,
        PH_PRE   = 2'd1,
        PH_OVER  = 2'd2,
        PH_SPENT = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]        action;
        logic              contact_level;
        logic              charge_permit;
        logic              discharge_permit;
        logic [FLAG_W-1:0] error_flags;
        logic [CELL_W-1:0] lowest_cell;
        logic [CELL_W-1:0] highest_cell;
    } t_in_beat;

    typedef struct packed {
        logic charge_enable_out;
        logic solar_precharge_out;
        logic discharge_enable_out;
        logic motor_precharge_out;
        logic hazards;
        logic fault_latched;
        logic cell_fault;
    } t_out_beat;

    typedef struct packed {
        logic enable;
        logic precharge;
    } t_seq_drv;

    typedef struct packed {
        logic charge_permit;
        logic discharge_permit;
        logic faulted;
        logic general_fault;
        logic cell_fault;
        logic hazards;
    } t_flt_stat;

endpackage

### src/pcfs_seq.sv
// one precharge sequence: phase machine and tick timer
module pcfs_seq
    import pcfs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_permit,
    input  logic              i_contact,
    input  logic              i_faulted,
    input  logic [TICK_W-1:0] i_pre_ticks,
    input  logic [TICK_W-1:0] i_ovl_ticks,
    output t_seq_drv          o_drv
);

    localparam int CW = (TIMER_BITS + 1 > TICK_W) ? TIMER_BITS + 1 : TICK_W;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [CW-1:0]         next_cnt;
    logic [CW-1:0]         limit;
    logic                  done;

    always_comb begin
        next_cnt = CW'({1'b0, r_timer}) + CW'(1);
        limit    = (r_phase == PH_PRE) ? CW'(i_pre_ticks) : CW'(i_ovl_ticks);
        // a short timer ends the phase at its all-ones value
        done     = (next_cnt >= limit) || (next_cnt >= CW'({TIMER_BITS{1'b1}}));
    end

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        if (i_step) begin
            if (i_faulted) begin
                if (r_phase == PH_PRE || r_phase == PH_OVER) begin
                    n_phase = PH_SPENT;
                    n_timer = '0;
                end
            end else begin
                unique case (r_phase)
                    PH_ARMED: begin
                        if (i_permit && i_contact) begin
                            n_phase = PH_PRE;
                            n_timer = '0;
                        end
                    end
                    PH_PRE, PH_OVER: begin
                        if (done) begin
                            n_phase = (r_phase == PH_PRE) ? PH_OVER : PH_SPENT;
                            n_timer = '0;
                        end else begin
                            n_timer = next_cnt[TIMER_BITS-1:0];
                        end
                    end
                    PH_SPENT: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // drives follow the phase after this beat
    always_comb begin
        o_drv.enable    = (n_phase == PH_OVER) || (n_phase == PH_SPENT);
        o_drv.precharge = (n_phase == PH_PRE) || (n_phase == PH_OVER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ARMED;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

`ifndef SYNTHESIS
    a_spent_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SPENT |=> r_phase == PH_SPENT)
        else $error("spent sequence left spent");
`endif

endmodule

### src/pcfs_fault.sv
// permit holding, contact tracking, error flags and cell limit faults
module pcfs_fault
    import pcfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_in_beat          i_in,
    input  logic [CELL_W-1:0] i_low_limit,
    input  logic [CELL_W-1:0] i_high_limit,
    output t_flt_stat         o_stat
);

    logic       r_chg_permit, n_chg_permit;
    logic       r_dis_permit, n_dis_permit;
    logic       r_strobe, n_strobe;
    logic       r_seen_high, n_seen_high;
    logic       r_general, n_general;
    logic       r_cell_fault, n_cell_fault;
    logic       r_first_strike, n_first_strike;
    logic [1:0] r_cell_cnt, n_cell_cnt;
    logic       out_of_range;

    assign out_of_range = (i_in.lowest_cell < i_low_limit) ||
                          (i_in.highest_cell > i_high_limit);

    always_comb begin
        n_chg_permit   = r_chg_permit;
        n_dis_permit   = r_dis_permit;
        n_strobe       = r_strobe;
        n_seen_high    = r_seen_high;
        n_general      = r_general;
        n_cell_fault   = r_cell_fault;
        n_first_strike = r_first_strike;
        n_cell_cnt     = r_cell_cnt;
        if (i_step) begin
            unique case (t_action'(i_in.action))
                ACT_TICK: begin
                    n_seen_high = r_seen_high | i_in.contact_level;
                    if (n_seen_high && !i_in.contact_level) begin
                        n_general = 1'b1;
                    end
                end
                ACT_PERMIT: begin
                    n_chg_permit = i_in.charge_permit;
                    n_dis_permit = i_in.discharge_permit;
                end
                ACT_ERRORS: begin
                    n_strobe = |i_in.error_flags;
                    if (n_strobe) begin
                        n_general = 1'b1;
                    end
                end
                ACT_CELL: begin
                    if (r_cell_cnt != CNT_SAT) begin
                        n_cell_cnt = r_cell_cnt + 2'd1;
                    end
                    // first violation only arms, the second one latches
                    if (out_of_range && n_cell_cnt == CNT_SAT) begin
                        if (!r_first_strike) begin
                            n_first_strike = 1'b1;
                        end else begin
                            n_cell_fault = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.charge_permit    = r_chg_permit;
        o_stat.discharge_permit = r_dis_permit;
        o_stat.faulted          = n_general || n_cell_fault;
        o_stat.general_fault    = n_general;
        o_stat.cell_fault       = n_cell_fault;
        o_stat.hazards          = n_strobe || n_general || n_cell_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_permit   <= 1'b0;
            r_dis_permit   <= 1'b0;
            r_strobe       <= 1'b0;
            r_seen_high    <= 1'b0;
            r_general      <= 1'b0;
            r_cell_fault   <= 1'b0;
            r_first_strike <= 1'b0;
            r_cell_cnt     <= '0;
        end else begin
            r_chg_permit   <= n_chg_permit;
            r_dis_permit   <= n_dis_permit;
            r_strobe       <= n_strobe;
            r_seen_high    <= n_seen_high;
            r_general      <= n_general;
            r_cell_fault   <= n_cell_fault;
            r_first_strike <= n_first_strike;
            r_cell_cnt     <= n_cell_cnt;
        end
    end

`ifndef SYNTHESIS
    a_general_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_general |=> r_general)
        else $error("general fault cleared without reset");
    a_cell_needs_strike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell_fault |-> r_first_strike && r_cell_cnt == CNT_SAT)
        else $error("cell fault without earlier strike");
    a_cell_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell_fault |=> r_cell_fault)
        else $error("cell fault cleared without reset");
`endif

endmodule

### src/pack_precharge_fault_sequencer.sv
// top level: config registers, input and result registers, sequencers
// Contactor controller for a battery pack. Each input beat is a tick, a relay
// permit message, an error flags message or a cell voltage message, and each
// beat yields exactly one result beat carrying the drive and fault state after
// it. One beat is taken every clock while o_in_stall is low; a result passes
// through the input register, then the result register behind the state
// update. While a finished result waits on a stalled output, the input
// register still takes one more beat, and then the input stalls until the
// result moves. The charge and discharge sequences each run once after reset:
// on a tick with permit held, contact high and no fault they precharge for
// precharge_ticks ticks, then hold enable and precharge together for
// overlap_ticks ticks, then leave enable alone. A contact drop after contact
// was seen high, any nonzero error flag, or a second out-of-range cell reading
// from the third message on latches a fault that forces all drives off until
// reset. The user must write configuration only while no beat is in flight;
// the block itself does not enforce it.
module pack_precharge_fault_sequencer
    import pcfs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [TICK_W-1:0] r_pre_ticks;
    logic [TICK_W-1:0] r_ovl_ticks;
    logic [CELL_W-1:0] r_low_limit;
    logic [CELL_W-1:0] r_high_limit;

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out, n_out;

    logic      out_free;
    logic      advance;
    logic      tick_step;
    t_flt_stat stat;
    t_seq_drv  chg_drv;
    t_seq_drv  dis_drv;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign tick_step  = advance && (t_action'(r_in.action) == ACT_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ticks  <= PRE_TICKS_RST;
            r_ovl_ticks  <= OVL_TICKS_RST;
            r_low_limit  <= LOW_CELL_RST;
            r_high_limit <= HIGH_CELL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRE_TICKS: r_pre_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_OVL_TICKS: r_ovl_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_LOW_CELL:  r_low_limit  <= i_cfg_data[CELL_W-1:0];
                CFG_HIGH_CELL: r_high_limit <= i_cfg_data[CELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    pcfs_fault u_fault (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_in         (r_in),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .o_stat       (stat)
    );

    pcfs_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_chg_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (tick_step),
        .i_permit    (stat.charge_permit),
        .i_contact   (r_in.contact_level),
        .i_faulted   (stat.faulted),
        .i_pre_ticks (r_pre_ticks),
        .i_ovl_ticks (r_ovl_ticks),
        .o_drv       (chg_drv)
    );

    pcfs_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dis_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (tick_step),
        .i_permit    (stat.discharge_permit),
        .i_contact   (r_in.contact_level),
        .i_faulted   (stat.faulted),
        .i_pre_ticks (r_pre_ticks),
        .i_ovl_ticks (r_ovl_ticks),
        .o_drv       (dis_drv)
    );

    always_comb begin
        n_out.charge_enable_out    = !stat.faulted && chg_drv.enable;
        n_out.solar_precharge_out  = !stat.faulted && chg_drv.precharge;
        n_out.discharge_enable_out = !stat.faulted && dis_drv.enable;
        n_out.motor_precharge_out  = !stat.faulted && dis_drv.precharge;
        n_out.hazards              = stat.hazards;
        n_out.fault_latched        = stat.general_fault;
        n_out.cell_fault           = stat.cell_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_fault_drives_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.fault_latched || o_out_data.cell_fault) |->
            !(o_out_data.charge_enable_out || o_out_data.solar_precharge_out ||
              o_out_data.discharge_enable_out || o_out_data.motor_precharge_out))
        else $error("drive high while a fault is latched");
`endif

endmodule

### tb/pack_precharge_fault_sequencer_tb.sv
// self-checking testbench for the pack precharge fault sequencer
module pack_precharge_fault_sequencer_tb;
    import pcfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TMR_MAX     = (1 << TIMER_BITS_DEF) - 1;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        bit                is_cfg;
        t_cfg_idx          reg_idx;
        logic [CFG_W-1:0]  reg_val;
        t_in_beat          beat;
        bit                typed;
        t_out_beat         want;
    } t_dir_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_beat             in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_beat            o_out_data;

    // predictor state and its copy of the registers
    logic [TICK_W-1:0]         pre_ticks = PRE_TICKS_RST;
    logic [TICK_W-1:0]         ovl_ticks = OVL_TICKS_RST;
    logic [CELL_W-1:0]         low_lim   = LOW_CELL_RST;
    logic [CELL_W-1:0]         high_lim  = HIGH_CELL_RST;
    t_phase                    chg_phase = PH_ARMED;
    t_phase                    dis_phase = PH_ARMED;
    logic [TIMER_BITS_DEF-1:0] chg_timer = '0;
    logic [TIMER_BITS_DEF-1:0] dis_timer = '0;
    logic chg_permit = 1'b0, dis_permit = 1'b0, strobe = 1'b0, contact_seen = 1'b0;
    logic gen_fault = 1'b0, cell_flt = 1'b0, first_strike = 1'b0;
    logic [1:0] cell_msgs = '0;
    bit   dis_reached_overlap = 1'b0;

    t_out_beat drive_status_due[$];
    t_dir_row  dir_rows[$];
    string     out_field[7] = '{"charge_enable_out", "solar_precharge_out",
                                "discharge_enable_out", "motor_precharge_out",
                                "hazards", "fault_latched", "cell_fault"};

    int idle_pct = 0, stall_pct = 0;
    int hold_asked = 0, hold_done = 0, hold_left = 0;
    int n_beats = 0, n_ticks = 0, n_checked = 0, mismatches = 0, quiet = 0;

    pack_precharge_fault_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void step_sequence(inout t_phase ph,
                                          inout logic [TIMER_BITS_DEF-1:0] tmr,
                                          input logic permit, input logic contact,
                                          input logic faulted);
        int nxt;
        int lim;
        if (faulted) begin
            if (ph == PH_PRE || ph == PH_OVER) begin
                ph  = PH_SPENT;
                tmr = '0;
            end
        end else if (ph == PH_ARMED) begin
            if (permit && contact) begin
                ph  = PH_PRE;
                tmr = '0;
            end
        end else if (ph != PH_SPENT) begin
            nxt = int'(tmr) + 1;
            lim = (ph == PH_PRE) ? int'(pre_ticks) : int'(ovl_ticks);
            // a zero register still ends the phase after one tick
            if (nxt >= lim || nxt >= TMR_MAX) begin
                ph  = (ph == PH_PRE) ? PH_OVER : PH_SPENT;
                tmr = '0;
            end else begin
                tmr = nxt[TIMER_BITS_DEF-1:0];
            end
        end
    endfunction

    function automatic t_out_beat next_drive_status(t_in_beat b);
        t_out_beat r;
        logic drv;
        case (b.action)
            ACT_TICK: begin
                // contact tracking comes before the sequences move
                if (b.contact_level) contact_seen = 1'b1;
                if (contact_seen && !b.contact_level) gen_fault = 1'b1;
                step_sequence(chg_phase, chg_timer, chg_permit, b.contact_level,
                              gen_fault | cell_flt);
                step_sequence(dis_phase, dis_timer, dis_permit, b.contact_level,
                              gen_fault | cell_flt);
            end
            ACT_PERMIT: begin
                chg_permit = b.charge_permit;
                dis_permit = b.discharge_permit;
            end
            ACT_ERRORS: begin
                strobe = |b.error_flags;
                if (strobe) gen_fault = 1'b1;
            end
            default: begin
                if (cell_msgs != CNT_SAT) cell_msgs = cell_msgs + 2'd1;
                if ((b.lowest_cell < low_lim || b.highest_cell > high_lim)
                        && cell_msgs == CNT_SAT) begin
                    if (first_strike) cell_flt = 1'b1;
                    first_strike = 1'b1;
                end
            end
        endcase
        if (dis_phase == PH_OVER) dis_reached_overlap = 1'b1;
        drv = !(gen_fault || cell_flt);
        r.charge_enable_out    = drv && (chg_phase == PH_OVER || chg_phase == PH_SPENT);
        r.solar_precharge_out  = drv && (chg_phase == PH_PRE || chg_phase == PH_OVER);
        r.discharge_enable_out = drv && (dis_phase == PH_OVER || dis_phase == PH_SPENT);
        r.motor_precharge_out  = drv && (dis_phase == PH_PRE || dis_phase == PH_OVER);
        r.hazards              = strobe || gen_fault || cell_flt;
        r.fault_latched        = gen_fault;
        r.cell_fault           = cell_flt;
        return r;
    endfunction

    // clean beats never latch a fault; dis_ok lets the discharge permit through
    function automatic t_in_beat rand_beat(bit clean, bit dis_ok);
        t_in_beat b;
        int pick;
        b.contact_level    = 1'($urandom_range(1, 0));
        b.charge_permit    = 1'($urandom_range(1, 0));
        b.discharge_permit = dis_ok ? 1'($urandom_range(1, 0)) : 1'b0;
        b.error_flags      = FLAG_W'($urandom);
        b.lowest_cell      = CELL_W'($urandom);
        b.highest_cell     = CELL_W'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < (clean ? 70 : 55)) begin
            b.action        = ACT_TICK;
            b.contact_level = clean ? 1'b1 : ($urandom_range(99, 0) >= 5);
        end else if (pick < (clean ? 80 : 70)) begin
            b.action = ACT_PERMIT;
        end else if (pick < 85 || (clean && pick < 90)) begin
            b.action = ACT_ERRORS;
            if (clean || $urandom_range(1, 0) == 0)
                b.error_flags = '0;
            else if ($urandom_range(1, 0) == 0)
                b.error_flags = FLAG_W'(1) << $urandom_range(FLAG_W - 1, 0);
        end else begin
            b.action = ACT_CELL;
            if (clean) begin
                b.lowest_cell  = CELL_W'($urandom_range(16'hFFFF, low_lim));
                b.highest_cell = CELL_W'($urandom_range(high_lim, 0));
            end
        end
        return b;
    endfunction

    function automatic t_dir_row beat_row(t_action act, bit c, bit cp, bit dp,
                                          logic [FLAG_W-1:0] flags,
                                          logic [CELL_W-1:0] lo, logic [CELL_W-1:0] hi,
                                          bit typed, logic [6:0] want);
        t_dir_row r;
        r.is_cfg  = 1'b0;
        r.reg_idx = CFG_PRE_TICKS;
        r.reg_val = '0;
        r.beat    = '{action: act, contact_level: c, charge_permit: cp,
                      discharge_permit: dp, error_flags: flags, lowest_cell: lo,
                      highest_cell: hi};
        r.typed   = typed;
        r.want    = t_out_beat'(want);
        return r;
    endfunction

    function automatic t_dir_row cfg_row(t_cfg_idx idx, logic [CFG_W-1:0] val);
        t_dir_row r;
        r         = beat_row(ACT_TICK, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat pred;
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (o_in_stall);
        pred = next_drive_status(b);
        drive_status_due.push_back(typed ? want : pred);
        n_beats++;
        if (b.action == ACT_TICK) n_ticks++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_status_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PRE_TICKS: pre_ticks = val[TICK_W-1:0];
            CFG_OVL_TICKS: ovl_ticks = val[TICK_W-1:0];
            CFG_LOW_CELL:  low_lim   = val;
            default:       high_lim  = val;
        endcase
    endtask

    // receiver: a long hold-off on request, random stalls otherwise
    always @(negedge clk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (drive_status_due.size() == 0) begin
                mismatches++;
                $display("%0t: result beat %b with nothing expected", $time, o_out_data);
            end else begin
                want = drive_status_due.pop_front();
                n_checked++;
                for (int k = 0; k < 7; k++) begin
                    if (o_out_data[6-k] !== want[6-k]) begin
                        mismatches++;
                        $display("%0t: %s expected %b, got %b", $time, out_field[k],
                                 want[6-k], o_out_data[6-k]);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet, drive_status_due.size());
                $display("** pack_precharge_fault_sequencer: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int n;
        // action, contact, charge/discharge permit, flags, lowest, highest, typed, want
        dir_rows.push_back(beat_row(ACT_TICK, 0, 0, 0, '0, '0, '0, 1, 7'b0000000));
        dir_rows.push_back(beat_row(ACT_ERRORS, 0, 0, 0, '0, '0, '0, 1, 7'b0000000));
        // first two cell messages never count against the limits
        dir_rows.push_back(beat_row(ACT_CELL, 0, 0, 0, '0, '0, 16'hFFFF, 1, 7'b0000000));
        dir_rows.push_back(beat_row(ACT_CELL, 1, 1, 1, '0, 16'hFFFF, 16'hFFFF, 1, 7'b0000000));
        dir_rows.push_back(beat_row(ACT_PERMIT, 0, 1, 0, '0, '0, '0, 1, 7'b0000000));
        // contact never seen high: a low level is no fault and starts nothing
        dir_rows.push_back(beat_row(ACT_TICK, 0, 0, 0, '0, '0, '0, 1, 7'b0000000));
        dir_rows.push_back(cfg_row(CFG_PRE_TICKS, '0));
        dir_rows.push_back(cfg_row(CFG_OVL_TICKS, CFG_W'(1)));
        dir_rows.push_back(beat_row(ACT_TICK, 1, 0, 0, '0, '0, '0, 1, 7'b0100000));
        // zero precharge register counts as one tick
        dir_rows.push_back(beat_row(ACT_TICK, 1, 0, 0, '0, '0, '0, 1, 7'b1100000));
        dir_rows.push_back(beat_row(ACT_TICK, 1, 0, 0, '0, '0, '0, 1, 7'b1000000));
        dir_rows.push_back(beat_row(ACT_CELL, 1, 0, 0, '0, CELL_W'(27500), CELL_W'(42000),
                                    0, '0));
        dir_rows.push_back(beat_row(ACT_PERMIT, 1, 0, 0, 13'h1FFF, '0, '0, 0, '0));
        dir_rows.push_back(beat_row(ACT_TICK, 1, 1, 1, '0, '0, '0, 0, '0));
        dir_rows.push_back(cfg_row(CFG_LOW_CELL, '0));
        dir_rows.push_back(cfg_row(CFG_HIGH_CELL, 16'hFFFF));
        dir_rows.push_back(beat_row(ACT_CELL, 0, 1, 1, 13'h1FFF, '0, 16'hFFFF, 0, '0));
        dir_rows.push_back(beat_row(ACT_PERMIT, 1, 1, 0, 13'h1FFF, 16'hFFFF, '0, 0, '0));
        // fields that belong to other actions are ignored on a tick
        dir_rows.push_back(beat_row(ACT_TICK, 1, 1, 1, 13'h1FFF, 16'hFFFF, 16'hFFFF, 0, '0));
        dir_rows.push_back(beat_row(ACT_ERRORS, 1, 1, 1, '0, 16'hFFFF, '0, 0, '0));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // short sequences, discharge kept armed, no idling
        drain_results();
        write_reg(CFG_PRE_TICKS, CFG_W'($urandom_range(40, 1)));
        write_reg(CFG_OVL_TICKS, CFG_W'($urandom_range(40, 1)));
        write_reg(CFG_LOW_CELL, CFG_W'($urandom_range(30000, 20000)));
        write_reg(CFG_HIGH_CELL, CFG_W'($urandom_range(50000, 40000)));
        for (n = 0; n < 200; n++) begin
            if (n == 100) hold_asked++;
            if (n == 150) drain_results();
            send_beat(rand_beat(1'b1, 1'b0), 1'b0, '0);
        end

        // longer precharge: run discharge until it reaches overlap
        drain_results();
        idle_pct = 55;
        write_reg(CFG_PRE_TICKS, CFG_W'($urandom_range(80, 40)));
        write_reg(CFG_OVL_TICKS, CFG_W'(TMR_MAX));
        write_reg(CFG_LOW_CELL, CFG_W'($urandom));
        write_reg(CFG_HIGH_CELL, CFG_W'($urandom));
        n = 0;
        while (dis_phase != PH_OVER && n < 600) begin
            send_beat(rand_beat(1'b1, 1'b1), 1'b0, '0);
            n++;
        end
        repeat (20) send_beat(rand_beat(1'b1, 1'b1), 1'b0, '0);

        // overlap shortened mid-sequence, receiver stalling
        drain_results();
        idle_pct  = 0;
        stall_pct = 55;
        write_reg(CFG_OVL_TICKS, CFG_W'(2000));
        write_reg(CFG_PRE_TICKS, CFG_W'($urandom_range(TMR_MAX, 1)));
        write_reg(CFG_LOW_CELL, CFG_W'($urandom));
        write_reg(CFG_HIGH_CELL, CFG_W'($urandom));
        repeat (150) send_beat(rand_beat(1'b1, 1'b1), 1'b0, '0);

        // faults allowed: contact drops, error flags, repeated bad cells
        drain_results();
        idle_pct  = 29;
        stall_pct = 29;
        write_reg(CFG_LOW_CELL, CFG_W'($urandom));
        write_reg(CFG_HIGH_CELL, CFG_W'($urandom));
        repeat (150) send_beat(rand_beat(1'b0, 1'b1), 1'b0, '0);

        // every reading out of range
        drain_results();
        idle_pct  = 55;
        stall_pct = 55;
        write_reg(CFG_LOW_CELL, 16'hFFFF);
        write_reg(CFG_HIGH_CELL, '0);
        repeat (100) send_beat(rand_beat(1'b0, 1'b1), 1'b0, '0);

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d input beats (%0d ticks), %0d result beats checked",
                 n_beats, n_ticks, n_checked);
        $display("discharge reached overlap: %0b, general fault: %0b, cell fault: %0b",
                 dis_reached_overlap, gen_fault, cell_flt);
        if (mismatches == 0) begin
            $display("** pack_precharge_fault_sequencer: PASSED **");
        end else begin
            $display("** pack_precharge_fault_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
src/pcfs_pkg.sv
src/pcfs_seq.sv
src/pcfs_fault.sv
src/pack_precharge_fault_sequencer.sv
tb/pack_precharge_fault_sequencer_tb.sv
